// ===== rtl/ntpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpa_pkg
// Shared widths, angle constants, arctangent table and the CORDIC request type.
// ----------------------------------------------------------------------------
package ntpa_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int POS_FRAC_BITS_DEF = 8;

  localparam int POS_W   = 24;
  localparam int DIFF_W  = 25;
  localparam int DIST_W  = 50;
  localparam int CX_W    = 28;
  localparam int ANG_W   = 21;
  localparam int CIN_W   = 26;

  // angles in 1/2048 degree
  localparam logic signed [ANG_W-1:0] DEG180 = 21'sd368640;
  localparam logic signed [ANG_W-1:0] DEG90  = 21'sd184320;

  localparam logic [2:0] REG_OWN_X = 3'd0;
  localparam logic [2:0] REG_OWN_Y = 3'd1;
  localparam logic [2:0] REG_OWN_Z = 3'd2;
  localparam logic [2:0] REG_TEAM  = 3'd3;
  localparam logic [2:0] REG_RANGE = 3'd4;

  typedef struct packed {
    logic                    start;
    logic signed [CIN_W-1:0] x;
    logic signed [CIN_W-1:0] y;
  } cordic_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ANG_W-1:0] angle;
  } cordic_rsp_t;

  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 21'sd92160;
      5'd1:  v = 21'sd54405;
      5'd2:  v = 21'sd28746;
      5'd3:  v = 21'sd14592;
      5'd4:  v = 21'sd7324;
      5'd5:  v = 21'sd3666;
      5'd6:  v = 21'sd1833;
      5'd7:  v = 21'sd917;
      5'd8:  v = 21'sd458;
      5'd9:  v = 21'sd229;
      5'd10: v = 21'sd115;
      5'd11: v = 21'sd57;
      5'd12: v = 21'sd29;
      5'd13: v = 21'sd14;
      5'd14: v = 21'sd7;
      5'd15: v = 21'sd4;
      5'd16: v = 21'sd2;
      5'd17: v = 21'sd1;
      default: v = 21'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/nearest_target_pointing_angles_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_target_pointing_angles_top
// Nearest eligible candidate search with CORDIC yaw/pitch toward the winner.
// ----------------------------------------------------------------------------
// Usage:
//  - Config: cfg_we/cfg_addr/cfg_wdata write own_x/y/z, own_team, range limit;
//    write only while idle. Unknown indexes are ignored.
//  - Input channel in_valid/in_ready carries one candidate per transaction.
//    Each candidate passes through accept, the shared 25x25 squarer
//    (three squares, accumulate) and a compare step.
//  - On a candidate with last=1 one result transaction follows on
//    out_valid/out_ready. With a winner that adds a squarer pass (dx, dy),
//    a bit-serial square root (one result bit per iteration) and two
//    CORDIC runs, yaw and then pitch.
//    Without a winner the compare goes straight to the result state.
//  - The result sits in an output register; new candidates are taken while
//    it waits. A following scan end holds until the receiver takes it.
//  - rst (synchronous) clears the scan, drops out_valid and restores the
//    register reset values.
// ----------------------------------------------------------------------------
module nearest_target_pointing_angles_top #(
  parameter int CORDIC_STEPS  = ntpa_pkg::CORDIC_STEPS_DEF,
  parameter int POS_FRAC_BITS = ntpa_pkg::POS_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [49:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               entry_valid,
  input  logic               line_of_sight,
  input  logic [7:0]         team,
  input  logic [7:0]         alive_state,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               target_found,
  output logic signed [15:0] yaw,
  output logic signed [13:0] pitch
);

  localparam int DW = ntpa_pkg::DIFF_W;
  localparam int LW = ntpa_pkg::DIST_W;
  localparam int AW = ntpa_pkg::ANG_W;
  localparam logic [LW-1:0] RANGE_RST = LW'(64'd9999999 << (2 * POS_FRAC_BITS));

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ     = 4'd1;
  localparam logic [3:0] S_CMP    = 4'd2;
  localparam logic [3:0] S_PSQ    = 4'd3;
  localparam logic [3:0] S_SQRT   = 4'd4;
  localparam logic [3:0] S_YAW_GO = 4'd5;
  localparam logic [3:0] S_YAW    = 4'd6;
  localparam logic [3:0] S_PIT_GO = 4'd7;
  localparam logic [3:0] S_PIT    = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0] state;

  // configuration
  logic signed [23:0] own_x, own_y, own_z;
  logic [7:0]         own_team;
  logic [LW-1:0]      range_limit_sq;

  // current candidate
  logic signed [DW-1:0] dx, dy, dz;
  logic                 pre_ok;
  logic                 is_last;

  // scan state
  logic                 best_found;
  logic [LW-1:0]        best_distance_sq;
  logic signed [DW-1:0] best_dx, best_dy, best_dz;

  // shared squarer
  logic [1:0]           mcnt;
  logic signed [DW-1:0] mop;
  logic signed [LW-1:0] mope;
  logic [LW-1:0]        prod;
  logic [LW-1:0]        acc;

  // square root
  logic [LW-1:0]        sq_v, sq_r, sq_bit;
  logic [4:0]           sq_cnt;
  logic [LW-1:0]        sq_t;

  // angles
  logic signed [AW-1:0] yaw_ang;
  logic signed [AW-1:0] pit_sat;
  logic signed [AW-1:0] yaw_rnd, pit_rnd;

  ntpa_pkg::cordic_req_t creq;
  ntpa_pkg::cordic_rsp_t crsp;

  logic cand_ok;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_SQ: begin
        case (mcnt)
          2'd0:    mop = dx;
          2'd1:    mop = dy;
          default: mop = dz;
        endcase
      end
      S_PSQ:   mop = (mcnt == 2'd0) ? best_dx : best_dy;
      default: mop = dx;
    endcase
  end
  assign mope = LW'(mop);

  assign cand_ok = pre_ok && (acc < range_limit_sq) &&
                   (!best_found || acc < best_distance_sq);

  assign sq_t = sq_r + sq_bit;

  always_comb begin
    creq.start = (state == S_YAW_GO) || (state == S_PIT_GO);
    if (state == S_PIT_GO) begin
      creq.x = ntpa_pkg::CIN_W'(sq_r[DW-1:0]);
      creq.y = ntpa_pkg::CIN_W'(best_dz);
    end else begin
      creq.x = ntpa_pkg::CIN_W'(best_dx);
      creq.y = ntpa_pkg::CIN_W'(best_dy);
    end
  end

  ntpa_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  always_comb begin
    if (crsp.angle > ntpa_pkg::DEG90)       pit_sat = ntpa_pkg::DEG90;
    else if (crsp.angle < -ntpa_pkg::DEG90) pit_sat = -ntpa_pkg::DEG90;
    else                                    pit_sat = crsp.angle;
  end
  // round half up to 1/64 degree
  assign yaw_rnd = (yaw_ang + AW'(16)) >>> 5;
  assign pit_rnd = (pit_sat + AW'(16)) >>> 5;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_x          <= '0;
      own_y          <= '0;
      own_z          <= '0;
      own_team       <= '0;
      range_limit_sq <= RANGE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        ntpa_pkg::REG_OWN_X: own_x          <= cfg_wdata[23:0];
        ntpa_pkg::REG_OWN_Y: own_y          <= cfg_wdata[23:0];
        ntpa_pkg::REG_OWN_Z: own_z          <= cfg_wdata[23:0];
        ntpa_pkg::REG_TEAM:  own_team       <= cfg_wdata[7:0];
        ntpa_pkg::REG_RANGE: range_limit_sq <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= LW'(mope * mope);
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      best_found       <= 1'b0;
      best_distance_sq <= '0;
      best_dx          <= '0;
      best_dy          <= '0;
      best_dz          <= '0;
      mcnt             <= '0;
    end else begin
      // S_FIN reloads the output register itself
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            dx      <= DW'(pos_x) - DW'(own_x);
            dy      <= DW'(pos_y) - DW'(own_y);
            dz      <= DW'(pos_z) - DW'(own_z);
            pre_ok  <= entry_valid && line_of_sight && (team != own_team) &&
                       (alive_state == 8'd0);
            is_last <= last;
            mcnt    <= '0;
            state   <= S_SQ;
          end
        end
        S_SQ: begin
          // square issued at mcnt, summed from the prod register in the next cycle
          acc  <= (mcnt == 2'd0) ? '0 : (mcnt == 2'd1) ? prod : acc + prod;
          mcnt <= mcnt + 1'b1;
          if (mcnt == 2'd3) state <= S_CMP;
        end
        S_CMP: begin
          mcnt <= '0;
          if (cand_ok) begin
            best_found       <= 1'b1;
            best_distance_sq <= acc;
            best_dx          <= dx;
            best_dy          <= dy;
            best_dz          <= dz;
          end
          if (!is_last)                      state <= S_IDLE;
          else if (cand_ok || best_found)    state <= S_PSQ;
          else                               state <= S_FIN;
        end
        S_PSQ: begin
          acc  <= prod;
          mcnt <= mcnt + 1'b1;
          if (mcnt == 2'd2) begin
            sq_v   <= acc + prod;
            sq_r   <= '0;
            sq_bit <= LW'(1) << (LW - 2);
            sq_cnt <= '0;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_v >= sq_t) begin
            sq_v <= sq_v - sq_t;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 5'(LW / 2 - 1)) state <= S_YAW_GO;
        end
        S_YAW_GO: state <= S_YAW;
        S_YAW: begin
          if (crsp.done) begin
            yaw_ang <= crsp.angle;
            state   <= S_PIT_GO;
          end
        end
        S_PIT_GO: state <= S_PIT;
        S_PIT: begin
          if (crsp.done) state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            target_found     <= best_found;
            yaw              <= best_found ? 16'(yaw_rnd) + 16'sd5760 : '0;
            pitch            <= best_found ? 14'(pit_rnd) : '0;
            best_found       <= 1'b0;
            best_distance_sq <= '0;
            best_dx          <= '0;
            best_dy          <= '0;
            best_dz          <= '0;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !target_found) |-> (yaw == 16'sd0 && pitch == 14'sd0))
    else $error("no target but nonzero angles");
  a_pitch_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch <= 14'sd5760 && pitch >= -14'sd5760))
    else $error("pitch out of range");
  a_scan_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!out_valid || out_ready)) |=> !best_found)
    else $error("scan state not cleared after result");
`endif

endmodule

// ===== rtl/ntpa_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpa_cordic
// Iterative vectoring CORDIC, one micro-rotation per cycle; atan2(y, x).
// ----------------------------------------------------------------------------
module ntpa_cordic #(
  parameter int STEPS = ntpa_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ntpa_pkg::cordic_req_t req,
  output ntpa_pkg::cordic_rsp_t rsp
);

  localparam int IW = $clog2(STEPS);

  logic                                busy;
  logic                                done;
  logic [IW-1:0]                       i;
  logic signed [ntpa_pkg::CX_W-1:0]    x;
  logic signed [ntpa_pkg::CX_W-1:0]    y;
  logic signed [ntpa_pkg::ANG_W-1:0]   z;
  logic signed [ntpa_pkg::CX_W-1:0]    xs;
  logic signed [ntpa_pkg::CX_W-1:0]    ys;
  logic signed [ntpa_pkg::CX_W-1:0]    x0;
  logic signed [ntpa_pkg::CX_W-1:0]    y0;
  logic signed [ntpa_pkg::ANG_W-1:0]   at;

  assign x0 = ntpa_pkg::CX_W'(req.x);
  assign y0 = ntpa_pkg::CX_W'(req.y);
  assign xs = x >>> i;
  assign ys = y >>> i;
  assign at = ntpa_pkg::atan_tab(5'(i));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        i <= '0;
        if (x0 == '0 && y0 == '0) begin
          z    <= '0;
          done <= 1'b1;
        end else if (x0 < 0) begin
          z    <= (y0 >= 0) ? ntpa_pkg::DEG180 : -ntpa_pkg::DEG180;
          x    <= -x0;
          y    <= -y0;
          busy <= 1'b1;
        end else begin
          z    <= '0;
          x    <= x0;
          y    <= y0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end
        if (i == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          i <= i + 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    if (z > ntpa_pkg::DEG180)       rsp.angle = ntpa_pkg::DEG180;
    else if (z < -ntpa_pkg::DEG180) rsp.angle = -ntpa_pkg::DEG180;
    else                            rsp.angle = z;
  end

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst) busy |-> !req.start)
    else $error("cordic restarted while busy");
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("cordic done while busy");
  a_angle_sat: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.angle <= ntpa_pkg::DEG180 && rsp.angle >= -ntpa_pkg::DEG180))
    else $error("cordic angle out of range");
`endif

endmodule
